// ----- src/khfr_pkg.sv -----
// shared types and constants for the key hit frequency ranking block
// used by khfr_cell and key_hit_frequency_ranking_top
package khfr_pkg;

    localparam int KEY_SLOTS    = 256;
    localparam int BUTTON_SLOTS = 8;
    localparam int SLOTS        = KEY_SLOTS + BUTTON_SLOTS;

    localparam int ID_W  = 9;
    localparam int CNT_W = 24;
    localparam int TOT_W = 32;

    localparam logic [ID_W-1:0]  IDX_LAST  = ID_W'(SLOTS - 1);
    localparam logic [ID_W-1:0]  SLOTS_ID  = ID_W'(SLOTS);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [TOT_W-1:0] TOT_MAX   = '1;

    localparam logic [1:0] CMD_PRESS   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  key;
        logic [CNT_W-1:0] count;
        logic             held;
    } t_entry;

endpackage

// ----- src/key_hit_frequency_ranking_top.sv -----
// Press counter with a ranked list held in a ring of cells, one cell per rank position.
// During a pass the ring rotates one entry per cycle past a head cell, so a full pass
// visits all 264 entries. Release, query and a press of a held key take one pass;
// a counted press takes three passes (locate, find new rank, reorder). Out of range
// requests answer without a pass. One transaction is worked on at a time; a new one
// is accepted while the previous result waits.
// depends on khfr_pkg and khfr_cell
module key_hit_frequency_ranking_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // cmd, key_id, rank_pos
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata   // entry_key, entry_count, entry_rank,
                                       // entry_held, entry_present, total_hits
);
    import khfr_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_FINDQ, S_MOVE, S_RESP} t_state;

    t_state            r_state;
    logic [1:0]        r_cmd;
    logic [ID_W-1:0]   r_id, r_pos, r_k, r_p, r_q, r_fkey;
    logic [CNT_W-1:0]  r_c, r_nc;
    logic              r_held, r_bad, r_moved;
    logic [TOT_W-1:0]  r_total;
    t_entry            r_carry;
    logic              r_m_valid;
    logic [79:0]       r_m_data;

    t_entry cell_out [SLOTS];
    t_entry head, wb;
    logic   shift, hit, last;

    logic [1:0]      in_cmd;
    logic [ID_W-1:0] in_id, in_pos;

    logic [ID_W-1:0]  o_key, o_rank;
    logic [CNT_W-1:0] o_cnt;
    logic             o_held;

    assign in_cmd = s_axis_tdata[1:0];
    assign in_id  = s_axis_tdata[10:2];
    assign in_pos = s_axis_tdata[19:11];

    assign head  = cell_out[0];
    assign shift = (r_state == S_SCAN) || (r_state == S_FINDQ) || (r_state == S_MOVE);
    assign last  = (r_k == IDX_LAST);
    assign hit   = (r_cmd == CMD_QUERY) ? (r_k == r_pos) : (head.key == r_id);

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_ring
            khfr_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (shift),
                .i_init_key (ID_W'(gi)),
                .i_entry    ((gi == SLOTS - 1) ? wb : cell_out[(gi + 1) % SLOTS]),
                .o_entry    (cell_out[gi])
            );
        end
    endgenerate

    // value written back at the tail of the ring
    always_comb begin
        wb = head;
        case (r_state)
            S_SCAN: begin
                if (r_cmd == CMD_RELEASE && head.key == r_id) wb.held = 1'b0;
            end
            S_MOVE: begin
                if (r_k == r_q) begin
                    wb.key   = r_id;
                    wb.count = r_nc;
                    wb.held  = 1'b1;
                end else if (r_k > r_q && r_k <= r_p) begin
                    wb = r_carry;
                end
            end
            default: wb = head;
        endcase
    end

    always_comb begin
        o_key  = (r_cmd == CMD_PRESS || r_cmd == CMD_RELEASE) ? r_id : r_fkey;
        o_cnt  = r_moved ? r_nc : r_c;
        o_rank = r_moved ? r_q : r_p;
        if (r_bad)                  o_held = 1'b0;
        else if (r_cmd == CMD_PRESS) o_held = 1'b1;
        else if (r_cmd == CMD_QUERY) o_held = r_held;
        else                         o_held = 1'b0;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (m_axis_tready && r_state != S_RESP) r_m_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= in_cmd;
                        r_id    <= in_id;
                        r_pos   <= in_pos;
                        r_k     <= '0;
                        r_p     <= '0;
                        r_c     <= '0;
                        r_held  <= 1'b0;
                        r_fkey  <= '0;
                        r_moved <= 1'b0;
                        r_bad   <= 1'b0;
                        case (in_cmd)
                            CMD_PRESS, CMD_RELEASE: begin
                                if (in_id >= SLOTS_ID) begin
                                    r_bad   <= 1'b1;
                                    r_state <= S_RESP;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_QUERY: begin
                                if (in_pos >= SLOTS_ID) begin
                                    r_p     <= in_pos;
                                    r_state <= S_RESP;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_bad   <= 1'b1;
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_p    <= r_k;
                        r_c    <= head.count;
                        r_held <= head.held;
                        r_fkey <= head.key;
                    end
                    r_k <= last ? '0 : r_k + 1'b1;
                    if (last) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_q <= '0;
                    if (r_cmd == CMD_PRESS && !r_held) begin
                        r_nc    <= (r_c == CNT_MAX) ? r_c : r_c + 1'b1;
                        r_total <= (r_total == TOT_MAX) ? r_total : r_total + 1'b1;
                        r_state <= S_FINDQ;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_FINDQ: begin
                    if (r_k < r_p && head.count > r_nc) r_q <= r_k + 1'b1;
                    r_k <= last ? '0 : r_k + 1'b1;
                    if (last) r_state <= S_MOVE;
                end
                S_MOVE: begin
                    if (r_k >= r_q && r_k <= r_p) r_carry <= head;
                    r_k <= last ? '0 : r_k + 1'b1;
                    if (last) begin
                        r_moved <= 1'b1;
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {4'b0, r_total, (o_cnt != '0), o_held,
                                      o_rank, o_cnt, o_key};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/khfr_cell.sv -----
// one rank position of the ring: key, count and held flag
// depends on khfr_pkg
module khfr_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_shift,
    input  logic [khfr_pkg::ID_W-1:0] i_init_key,
    input  khfr_pkg::t_entry          i_entry,
    output khfr_pkg::t_entry          o_entry
);
    import khfr_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.key   <= i_init_key;
            r_entry.count <= '0;
            r_entry.held  <= 1'b0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule
